// ===== hw/rtl/restart_interval_schedule_top_macros.svh =====
// Assertion macros for the restart interval schedule block.
// Include from any module that has clk_i and rst_ni in scope.
`ifndef RESTART_INTERVAL_SCHEDULE_TOP_MACROS_SVH
`define RESTART_INTERVAL_SCHEDULE_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define RIS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition is followed by another one in the next cycle.
`define RIS_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== hw/rtl/ris_pkg.sv =====
// Shared types, constants and helpers for the restart interval schedule block.
// No dependencies; the interfaces, the top and the multiplier refer to it by scoped names.
package ris_pkg;

  // Field and register widths
  localparam int ITER_FIELD_W = 31;
  localparam int ITER_WIDTH_DEF = 31;
  localparam int OUT_W = 31;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W = 2;

  // Serial multiplier geometry
  localparam int MUL_W = 48;
  localparam int DIG_W = 4;
  localparam int MUL_DIGITS = MUL_W / DIG_W;
  localparam int MUL_CNT_W = $clog2(MUL_DIGITS + 1);
  localparam int PROD_W = 2 * MUL_W;
  localparam int RES_W = 48;
  localparam int QSHIFT = 16;

  // Fixed-point constants
  localparam logic [MUL_W-1:0] Q_ONE = 48'h0000_0001_0000;
  localparam logic [MUL_W-1:0] Q_CAP = 48'h8000_0000_0000;
  localparam logic [OUT_W-1:0] OUT_MAX = 31'h7FFF_FFFF;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROWTH = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0] BASE_RST = 16'd100;
  localparam logic [CFG_W-1:0] GROWTH_RST = 16'd384;

  typedef enum logic [MODE_W-1:0] {
    MODE_CONST  = 2'd0,
    MODE_LINEAR = 2'd1,
    MODE_GEO    = 2'd2,
    MODE_LUBY   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LUBY,
    ST_GEO_CHK,
    ST_GEO_ACC,
    ST_GEO_SHIFT,
    ST_GEO_SQ,
    ST_SCALE,
    ST_EMIT
  } state_e;

  // Request to the serial multiplier
  typedef struct packed {
    logic             start;
    logic [MUL_W-1:0] a;
    logic [MUL_W-1:0] b;
  } mul_req_t;

  // Status from the serial multiplier
  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

  // Drop the Q16 fraction of a product and clamp at Q_CAP, in the Q32.16 format
  function automatic logic [MUL_W-1:0] q_cap(input logic [PROD_W-1:0] p);
    logic over;
    over = (|p[PROD_W-1:MUL_W+QSHIFT]) || (p[MUL_W+QSHIFT-1:QSHIFT] > Q_CAP);
    return over ? Q_CAP : p[MUL_W+QSHIFT-1:QSHIFT];
  endfunction

endpackage

// ===== hw/rtl/ris_in_if.sv =====
// Input channel of the restart interval schedule block: one restart number per item.
// Depends on ris_pkg for the field width.
interface ris_in_if;
  logic                              valid;
  logic                              ready;
  logic [ris_pkg::ITER_FIELD_W-1:0]  iteration;

  modport source (output valid, output iteration, input ready);
  modport sink (input valid, input iteration, output ready);
endinterface

// ===== hw/rtl/ris_out_if.sv =====
// Output channel of the restart interval schedule block: one budget per item.
// Depends on ris_pkg for the field width.
interface ris_out_if;
  logic                       valid;
  logic                       ready;
  logic [ris_pkg::OUT_W-1:0]  interval;
  logic                       saturated;

  modport source (output valid, output interval, output saturated, input ready);
  modport sink (input valid, input interval, input saturated, output ready);
endinterface

// ===== hw/rtl/restart_interval_schedule_top.sv =====
// Restart interval schedule: one item in, one budget out, one item at a time.
// Constant mode passes the base straight to the output; linear and Luby modes take one product
// by the base, Luby after a scan of the restart number; geometric mode takes up to two products
// per exponent bit, then one by the base, on the 4-bit digit-serial multiplier; the input is
// ready again in the cycle the result enters the output register, where the result waits.
// Reset (async, active low) clears control state and loads mode Luby, base 100, factor 1.5.
module restart_interval_schedule_top #(
  parameter int ITER_WIDTH = ris_pkg::ITER_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ris_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [ris_pkg::CFG_W-1:0]       cfg_data_i,
  ris_in_if.sink                          in_i,
  ris_out_if.source                       out_o
);

  `include "restart_interval_schedule_top_macros.svh"

  // Configuration registers
  ris_pkg::mode_e               mode_q;
  logic [ris_pkg::CFG_W-1:0]    base_q;
  logic [ris_pkg::CFG_W-1:0]    growth_q;

  // Sequencer and datapath registers
  ris_pkg::state_e              state_q, state_d;
  logic [ITER_WIDTH-1:0]        v_q, v_d;
  logic [ITER_WIDTH-1:0]        h_q, h_d;
  logic [ris_pkg::MUL_W-1:0]    acc_q, acc_d;
  logic [ris_pkg::MUL_W-1:0]    sq_q, sq_d;
  logic [ris_pkg::RES_W-1:0]    res_q, res_d;
  logic                         geo_q, geo_d;

  // Output register
  logic                         out_valid_q, out_valid_d;
  logic [ris_pkg::OUT_W-1:0]    interval_q, interval_d;
  logic                         sat_q, sat_d;

  logic                         in_ready;
  logic [ITER_WIDTH-1:0]        it_raw;
  logic [ITER_WIDTH-1:0]        it_fix;
  logic [ITER_WIDTH-1:0]        vp1;
  logic [ITER_WIDTH-1:0]        term;
  logic [ris_pkg::MUL_W-1:0]    base_ext;
  logic                         res_sat;

  ris_pkg::mul_req_t            mul_req;
  ris_pkg::mul_rsp_t            mul_rsp;

  ris_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  // Restart number zero counts as restart one
  assign it_raw = in_i.iteration[ITER_WIDTH-1:0];
  assign it_fix = (it_raw == '0) ? ITER_WIDTH'(1) : it_raw;

  // Luby helpers: all-ones test and the term (v+1)/2 for odd v
  assign vp1 = v_q + ITER_WIDTH'(1);
  assign term = (v_q >> 1) + ITER_WIDTH'(1);

  assign base_ext = {{(ris_pkg::MUL_W - ris_pkg::CFG_W){1'b0}}, base_q};
  assign res_sat = |res_q[ris_pkg::RES_W-1:ris_pkg::OUT_W];

  // Write configuration registers; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ris_pkg::MODE_LUBY;
      base_q <= ris_pkg::BASE_RST;
      growth_q <= ris_pkg::GROWTH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ris_pkg::CFG_MODE:   mode_q <= ris_pkg::mode_e'(cfg_data_i[ris_pkg::MODE_W-1:0]);
        ris_pkg::CFG_BASE:   base_q <= cfg_data_i;
        ris_pkg::CFG_GROWTH: growth_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Sequence one item through the schedule term and the final scaling
  always_comb begin
    state_d = state_q;
    v_d = v_q;
    h_d = h_q;
    acc_d = acc_q;
    sq_d = sq_q;
    res_d = res_q;
    geo_d = geo_q;
    out_valid_d = out_valid_q;
    interval_d = interval_q;
    sat_d = sat_q;
    mul_req = '0;
    in_ready = 1'b0;

    // Drop the result once it is taken
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ris_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_i.valid) begin
          geo_d = 1'b0;
          unique case (mode_q)
            ris_pkg::MODE_CONST: begin
              res_d = {{(ris_pkg::RES_W - ris_pkg::CFG_W){1'b0}}, base_q};
              state_d = ris_pkg::ST_EMIT;
            end
            ris_pkg::MODE_LINEAR: begin
              mul_req.start = 1'b1;
              mul_req.a = {{(ris_pkg::MUL_W - ITER_WIDTH){1'b0}}, it_fix};
              mul_req.b = base_ext;
              state_d = ris_pkg::ST_SCALE;
            end
            ris_pkg::MODE_GEO: begin
              v_d = it_fix - ITER_WIDTH'(1);
              acc_d = ris_pkg::Q_ONE;
              sq_d = {{(ris_pkg::MUL_W - ris_pkg::CFG_W - 8){1'b0}}, growth_q, 8'h00};
              state_d = ris_pkg::ST_GEO_CHK;
            end
            ris_pkg::MODE_LUBY: begin
              v_d = it_fix;
              h_d = {1'b1, {(ITER_WIDTH - 1){1'b0}}};
              state_d = ris_pkg::ST_LUBY;
            end
            default: begin
            end
          endcase
        end
      end

      // Strip the top bit and add one until v is all ones; h walks down to it
      ris_pkg::ST_LUBY: begin
        if ((vp1 & v_q) == '0) begin
          mul_req.start = 1'b1;
          mul_req.a = {{(ris_pkg::MUL_W - ITER_WIDTH){1'b0}}, term};
          mul_req.b = base_ext;
          state_d = ris_pkg::ST_SCALE;
        end else begin
          if ((v_q & h_q) != '0) begin
            v_d = v_q - h_q + ITER_WIDTH'(1);
          end
          h_d = h_q >> 1;
        end
      end

      // Square-and-multiply over the exponent, low bit first
      ris_pkg::ST_GEO_CHK: begin
        mul_req.start = (v_q == '0) || v_q[0];
        if (v_q == '0) begin
          mul_req.a = acc_q;
          mul_req.b = base_ext;
          geo_d = 1'b1;
          state_d = ris_pkg::ST_SCALE;
        end else if (v_q[0]) begin
          mul_req.a = acc_q;
          mul_req.b = sq_q;
          state_d = ris_pkg::ST_GEO_ACC;
        end else begin
          state_d = ris_pkg::ST_GEO_SHIFT;
        end
      end

      ris_pkg::ST_GEO_ACC: begin
        if (mul_rsp.done) begin
          acc_d = ris_pkg::q_cap(mul_rsp.product);
          state_d = ris_pkg::ST_GEO_SHIFT;
        end
      end

      ris_pkg::ST_GEO_SHIFT: begin
        v_d = v_q >> 1;
        if ((v_q >> 1) != '0) begin
          mul_req.start = 1'b1;
          mul_req.a = sq_q;
          mul_req.b = sq_q;
          state_d = ris_pkg::ST_GEO_SQ;
        end else begin
          state_d = ris_pkg::ST_GEO_CHK;
        end
      end

      ris_pkg::ST_GEO_SQ: begin
        if (mul_rsp.done) begin
          sq_d = ris_pkg::q_cap(mul_rsp.product);
          state_d = ris_pkg::ST_GEO_CHK;
        end
      end

      // Scale by the base; the geometric power still carries its Q16 fraction
      ris_pkg::ST_SCALE: begin
        if (mul_rsp.done) begin
          res_d = geo_q ? mul_rsp.product[ris_pkg::RES_W+ris_pkg::QSHIFT-1:ris_pkg::QSHIFT]
                        : mul_rsp.product[ris_pkg::RES_W-1:0];
          state_d = ris_pkg::ST_EMIT;
        end
      end

      // Hand the clamped result to the output register once it is free
      ris_pkg::ST_EMIT: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          sat_d = res_sat;
          interval_d = res_sat ? ris_pkg::OUT_MAX : res_q[ris_pkg::OUT_W-1:0];
          state_d = ris_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = ris_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ris_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q <= v_d;
    h_q <= h_d;
    acc_q <= acc_d;
    sq_q <= sq_d;
    res_q <= res_d;
    geo_q <= geo_d;
    interval_q <= interval_d;
    sat_q <= sat_d;
  end

  assign in_i.ready = in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.interval = interval_q;
  assign out_o.saturated = sat_q;

  // Accepting an item leaves idle, so a second item cannot slip in behind it
  `RIS_ASSERT_NEXT(a_accept_leaves_idle, in_i.valid && in_i.ready, !in_i.ready,
                   "input still ready right after an item was accepted")
  // The multiplier is never running while the block waits for an item
  `RIS_ASSERT(a_idle_mul_quiet, in_i.ready |-> !mul_rsp.busy,
              "multiplier busy while the block is idle")
  // A product only completes in a state that consumes it
  `RIS_ASSERT(a_done_consumed, mul_rsp.done |-> (state_q == ris_pkg::ST_GEO_ACC ||
              state_q == ris_pkg::ST_GEO_SQ || state_q == ris_pkg::ST_SCALE),
              "multiplier finished with nobody waiting for the product")

endmodule

// ===== hw/rtl/ris_serial_mul.sv =====
// Digit-serial unsigned multiplier, 48 x 48 bits, one 4-bit digit of b per cycle.
// Depends on ris_pkg for widths and the request and status structs.
module ris_serial_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ris_pkg::mul_req_t req_i,
  output ris_pkg::mul_rsp_t rsp_o
);

  logic [ris_pkg::MUL_W-1:0]         a_q, a_d;
  logic [ris_pkg::MUL_W-1:0]         b_q, b_d;
  logic [ris_pkg::PROD_W-1:0]        p_q, p_d;
  logic [ris_pkg::MUL_CNT_W-1:0]     cnt_q, cnt_d;
  logic                              done_q, done_d;

  logic                                   running;
  logic [ris_pkg::MUL_W+ris_pkg::DIG_W-1:0] partial;
  logic [ris_pkg::MUL_W+ris_pkg::DIG_W:0]   sum;
  logic [ris_pkg::PROD_W:0]                 wide;

  assign running = (cnt_q != '0);

  // Add one digit's partial product into the upper half, then shift right a digit
  always_comb begin
    partial = a_q * b_q[ris_pkg::DIG_W-1:0];
    sum = (ris_pkg::MUL_W + ris_pkg::DIG_W + 1)'(p_q[ris_pkg::PROD_W-1:ris_pkg::MUL_W])
        + (ris_pkg::MUL_W + ris_pkg::DIG_W + 1)'(partial);
    wide = {sum, p_q[ris_pkg::MUL_W-1:ris_pkg::DIG_W]};
  end

  // Load on start, advance one digit per cycle while running
  always_comb begin
    a_d = a_q;
    b_d = b_q;
    p_d = p_q;
    cnt_d = cnt_q;
    done_d = running && (cnt_q == ris_pkg::MUL_CNT_W'(1));
    if (req_i.start) begin
      a_d = req_i.a;
      b_d = req_i.b;
      p_d = '0;
      cnt_d = ris_pkg::MUL_CNT_W'(ris_pkg::MUL_DIGITS);
    end else if (running) begin
      b_d = b_q >> ris_pkg::DIG_W;
      p_d = wide[ris_pkg::PROD_W-1:0];
      cnt_d = cnt_q - ris_pkg::MUL_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    p_q <= p_d;
  end

  assign rsp_o.busy = running;
  assign rsp_o.done = done_q;
  assign rsp_o.product = p_q;

endmodule
